// ===== hw/rtl/edge_counting_blind_positioner_core_macros.svh =====
// assertion macros for the blind positioner core
// used by the top level only, no other dependencies
`ifndef EDGE_COUNTING_BLIND_POSITIONER_CORE_MACROS_SVH
`define EDGE_COUNTING_BLIND_POSITIONER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ECBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecbp assertion failed");
`define ECBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecbp assertion failed");
`else
`define ECBP_ASSERT_NOW(lbl, ante, cons)
`define ECBP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ecbp_pkg.sv =====
// types, codes and helper functions for the blind positioner core
// no dependencies
package ecbp_pkg;

  localparam int POS_BITS = 16;
  localparam int OUT_BITS = 16;
  localparam int EXT_BITS = POS_BITS + OUT_BITS + 2;
  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [EXT_BITS-1:0] ext_t;
  typedef logic [OUT_BITS-1:0]        out_pos_t;

  localparam pos_t POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_SET_TARGET  = 3'd1,
    CMD_SET_MOTION  = 3'd2,
    CMD_MARK_BOTTOM = 3'd3,
    CMD_MARK_TOP    = 3'd4
  } cmd_t;

  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_INC  = 2'd1;
  localparam logic [1:0] MOT_DEC  = 2'd2;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_POS    = 3'd1;
  localparam logic [2:0] EV_MOTION = 3'd2;
  localparam logic [2:0] EV_TARGET = 3'd3;
  localparam logic [2:0] EV_BOTTOM = 3'd4;
  localparam logic [2:0] EV_TOP    = 3'd5;

  typedef struct packed {
    logic [1:0] motion;
    pos_t       pos;
    pos_t       goal;
    logic       goal_act;
    pos_t       limit;
    logic       prev_sense;
  } state_t;

  typedef struct packed {
    logic [2:0] ev;
    logic       last;
    logic [1:0] motion;
    out_pos_t   position;
    out_pos_t   target;
    logic       target_valid;
    out_pos_t   limit;
  } res_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic                room_two;
  } fifo_stat_t;

  function automatic ext_t widen(pos_t p);
    return ext_t'(p);
  endfunction

  function automatic pos_t clamp_ext(ext_t v);
    pos_t r;
    if (v > widen(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < widen(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic out_pos_t low_out(pos_t p);
    ext_t e;
    e = widen(p);
    return e[OUT_BITS-1:0];
  endfunction

  function automatic res_t snap(logic [2:0] ev, logic [1:0] motion, pos_t pos,
                                logic goal_act, pos_t goal, pos_t limit);
    res_t r;
    r.ev           = ev;
    r.last         = 1'b1;
    r.motion       = motion;
    r.position     = low_out(pos);
    r.target       = goal_act ? low_out(goal) : '0;
    r.target_valid = goal_act;
    r.limit        = low_out(limit);
    return r;
  endfunction

endpackage

// ===== hw/rtl/edge_counting_blind_positioner_core.sv =====
// top level of the blind positioner: state register, command logic, result queue
// depends on ecbp_pkg, ecbp_step, ecbp_res_fifo and the assertion macro header
//
// usage
// - input channel in_*: one command per transfer (tick with sense sample, set target,
//   set motion, mark bottom, mark top); ready/valid handshake
// - result channel out_*: one or two records per command, each with an event code and
//   a snapshot of motion, position, target and limit; out_last marks the final record
// - latency: records are queued at the transfer; out_valid is high the cycle after it
// - throughput: one command per cycle while the four-entry result queue has room
//   for two records; a command with two records gives them one after the other
// - state updates in the transfer cycle, so the next command sees it at once
// - reset: motor stopped, position, limit and target zero, no target active,
//   result queue empty, in_ready high from the first cycle after reset
// - receiver stall: records wait in the queue; in_ready drops once fewer than
//   two free entries remain and returns as records are taken
`include "edge_counting_blind_positioner_core_macros.svh"
module edge_counting_blind_positioner_core import ecbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic               in_sense,
  input  logic signed [15:0] in_goal,
  input  logic [1:0]         in_direction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_res,
  output logic               out_last,
  output logic               out_motor_up,
  output logic               out_motor_down,
  output logic [1:0]         out_motion,
  output logic signed [15:0] out_position,
  output logic signed [15:0] out_target_out,
  output logic               out_target_valid,
  output logic signed [15:0] out_limit_out
);

  state_t     st_r, st_nxt;
  res_t       res0, res1, head;
  logic       two_res;
  logic       in_xfer;
  fifo_stat_t fstat;

  ecbp_step u_step (
    .cur       (st_r),
    .command   (in_command),
    .sense     (in_sense),
    .goal      (in_goal),
    .direction (in_direction),
    .nxt       (st_nxt),
    .res0      (res0),
    .res1      (res1),
    .two_res   (two_res)
  );

  assign in_ready = fstat.room_two;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  ecbp_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_xfer),
    .push_two (two_res),
    .din0     (res0),
    .din1     (res1),
    .pop      (out_ready),
    .dout     (head),
    .stat     (fstat)
  );

  assign out_valid        = (fstat.count != '0);
  assign out_event_res    = head.ev;
  assign out_last         = head.last;
  assign out_motion       = head.motion;
  assign out_motor_up     = (head.motion == MOT_DEC);
  assign out_motor_down   = (head.motion == MOT_INC);
  assign out_position     = head.position;
  assign out_target_out   = head.target;
  assign out_target_valid = head.target_valid;
  assign out_limit_out    = head.limit;

  `ECBP_ASSERT_NOW(a_fill_bound, 1'b1, fstat.count <= CNT_BITS'(DEPTH))
  `ECBP_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid)
  `ECBP_ASSERT_NEXT(a_stopped_tick_holds, in_xfer && in_command == CMD_TICK && st_r.motion == MOT_STOP, st_r == $past(st_r))
  `ECBP_ASSERT_NOW(a_motor_excl, out_valid, !(out_motor_up && out_motor_down))

endmodule

// ===== hw/rtl/ecbp_step.sv =====
// next state and result records for one command
// depends on ecbp_pkg
module ecbp_step import ecbp_pkg::*; (
  input  state_t             cur,
  input  logic [2:0]         command,
  input  logic               sense,
  input  logic signed [15:0] goal,
  input  logic [1:0]         direction,
  output state_t             nxt,
  output res_t               res0,
  output res_t               res1,
  output logic               two_res
);

  logic [1:0] dir_eff;
  pos_t       pos_step;
  pos_t       goal_sat;
  logic       stepped;
  logic       reached;
  logic [1:0] tgt_mot;

  always_comb begin
    dir_eff = (direction == 2'd3) ? MOT_STOP : direction;
    if (cur.motion == MOT_DEC) begin
      pos_step = (cur.pos == POS_MIN) ? cur.pos : cur.pos - pos_t'(1);
    end else if (cur.motion == MOT_INC) begin
      pos_step = (cur.pos == POS_MAX) ? cur.pos : cur.pos + pos_t'(1);
    end else begin
      pos_step = cur.pos;
    end
    stepped  = (cur.motion != MOT_STOP) && (sense != cur.prev_sense);
    goal_sat = clamp_ext(ext_t'(goal));
    if (goal_sat > cur.pos) begin
      tgt_mot = MOT_INC;
    end else if (goal_sat < cur.pos) begin
      tgt_mot = MOT_DEC;
    end else begin
      tgt_mot = cur.motion;
    end
  end

  always_comb begin
    nxt     = cur;
    two_res = 1'b0;
    reached = 1'b0;
    res0    = snap(EV_NONE, cur.motion, cur.pos, cur.goal_act, cur.goal, cur.limit);
    res1    = res0;
    unique case (command)
      CMD_TICK: begin
        if (cur.motion != MOT_STOP) begin
          if (stepped) begin
            nxt.prev_sense = sense;
            nxt.pos        = pos_step;
          end
          reached = cur.goal_act &&
                    ((cur.motion == MOT_INC && nxt.pos >= cur.goal) ||
                     (cur.motion == MOT_DEC && nxt.pos <= cur.goal));
          if (reached) begin
            nxt.motion = MOT_STOP;
          end
          if (stepped) begin
            res0 = snap(EV_POS, cur.motion, nxt.pos, cur.goal_act, cur.goal, cur.limit);
            res1 = snap(EV_MOTION, MOT_STOP, nxt.pos, cur.goal_act, cur.goal, cur.limit);
            two_res = reached;
          end else if (reached) begin
            res0 = snap(EV_MOTION, MOT_STOP, cur.pos, cur.goal_act, cur.goal, cur.limit);
          end
        end
      end
      CMD_SET_TARGET: begin
        nxt.goal     = goal_sat;
        nxt.goal_act = 1'b1;
        nxt.motion   = tgt_mot;
        two_res      = (goal_sat != cur.pos);
        res0 = snap(EV_TARGET, cur.motion, cur.pos, 1'b1, goal_sat, cur.limit);
        res1 = snap(EV_MOTION, tgt_mot, cur.pos, 1'b1, goal_sat, cur.limit);
      end
      CMD_SET_MOTION: begin
        nxt.goal_act = 1'b0;
        nxt.motion   = dir_eff;
        res0 = snap((cur.motion != dir_eff) ? EV_MOTION : EV_NONE, dir_eff, cur.pos,
                    1'b0, cur.goal, cur.limit);
      end
      CMD_MARK_BOTTOM: begin
        nxt.limit = cur.pos;
        res0 = snap(EV_BOTTOM, cur.motion, cur.pos, cur.goal_act, cur.goal, cur.pos);
      end
      CMD_MARK_TOP: begin
        nxt.limit = clamp_ext(widen(cur.limit) - widen(cur.pos));
        if (cur.goal_act) begin
          nxt.goal = clamp_ext(widen(cur.goal) - widen(cur.pos));
        end
        nxt.pos = '0;
        res0 = snap(EV_TOP, cur.motion, nxt.pos, cur.goal_act, nxt.goal, nxt.limit);
      end
      default: begin
      end
    endcase
    res0.last = !two_res;
    res1.last = 1'b1;
  end

endmodule

// ===== hw/rtl/ecbp_res_fifo.sv =====
// result queue, takes one or two records per transfer and gives one per cycle while popped and not empty
// depends on ecbp_pkg
module ecbp_res_fifo import ecbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       push_two,
  input  res_t       din0,
  input  res_t       din1,
  input  logic       pop,
  output res_t       dout,
  output fifo_stat_t stat
);

  res_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] add_n;
  logic                do_pop;

  always_comb begin
    do_pop     = pop && (cnt_r != '0);
    add_n      = push ? (push_two ? CNT_BITS'(2) : CNT_BITS'(1)) : '0;
    wr_ptr_nxt = wr_ptr_r + add_n[PTR_BITS-1:0];
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + add_n - (do_pop ? CNT_BITS'(1) : CNT_BITS'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din0;
      if (push_two) begin
        mem_r[wr_ptr_r + PTR_BITS'(1)] <= din1;
      end
    end
  end

  assign dout          = mem_r[rd_ptr_r];
  assign stat.count    = cnt_r;
  assign stat.room_two = (cnt_r <= CNT_BITS'(DEPTH - 2));

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for edge_counting_blind_positioner_core: a command table,
// random command traffic and a few re-zero checks, checked against typed-in results or a local predictor
// depends on ecbp_pkg and the core rtl
module testbench;
  import ecbp_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam logic [1:0] MOT_SPARE   = 2'd3;

  localparam int RANDOM_ITEMS = 920;
  localparam int IDLE_PCT     = 29;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 760;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [2:0]         ev;
    logic               last;
    logic               up;
    logic               down;
    logic [1:0]         motion;
    logic [15:0]        position;
    logic [15:0]        target;
    logic               tvalid;
    logic [15:0]        limit;
  } posn_report_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               sense;
    logic signed [15:0] goal;
    logic [1:0]         dir;
    logic               known;
    posn_report_t       want;
  } plan_row_t;

  localparam posn_report_t NO_REPORT = '0;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_command;
  logic               in_sense;
  logic signed [15:0] in_goal;
  logic [1:0]         in_direction;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_event_res;
  logic               out_last;
  logic               out_motor_up;
  logic               out_motor_down;
  logic [1:0]         out_motion;
  logic signed [15:0] out_position;
  logic signed [15:0] out_target_out;
  logic               out_target_valid;
  logic signed [15:0] out_limit_out;

  edge_counting_blind_positioner_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sense         (in_sense),
    .in_goal          (in_goal),
    .in_direction     (in_direction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_last         (out_last),
    .out_motor_up     (out_motor_up),
    .out_motor_down   (out_motor_down),
    .out_motion       (out_motion),
    .out_position     (out_position),
    .out_target_out   (out_target_out),
    .out_target_valid (out_target_valid),
    .out_limit_out    (out_limit_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predicted blind state
  logic [1:0]         run_mode = MOT_STOP;
  logic signed [15:0] count_now = '0;
  logic signed [15:0] goal_now = '0;
  logic               goal_on = 1'b0;
  logic signed [15:0] limit_now = '0;
  logic               sense_prev = 1'b0;

  posn_report_t fresh[$];
  posn_report_t awaited[$];
  int           items_taken = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  logic         row_known = 1'b0;
  posn_report_t row_want = '0;

  wire calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch in %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
    end
    mismatches++;
  endtask

  function automatic logic signed [15:0] saturate(input int v);
    if (v > int'(POS_MAX)) begin
      return POS_MAX;
    end
    if (v < int'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[15:0];
  endfunction

  function automatic posn_report_t make_report(input logic [2:0] ev, input logic last,
                                               input logic [1:0] motion,
                                               input logic [15:0] position,
                                               input logic [15:0] target, input logic tvalid,
                                               input logic [15:0] limit);
    posn_report_t r;
    r.ev       = ev;
    r.last     = last;
    r.up       = (motion == MOT_DEC);
    r.down     = (motion == MOT_INC);
    r.motion   = motion;
    r.position = position;
    r.target   = target;
    r.tvalid   = tvalid;
    r.limit    = limit;
    return r;
  endfunction

  function automatic posn_report_t now_report(input logic [2:0] ev);
    return make_report(ev, 1'b0, run_mode, count_now, goal_on ? goal_now : 16'sd0, goal_on,
                       limit_now);
  endfunction

  function automatic void predict_command(input logic [2:0] cmd, input logic sense,
                                          input logic signed [15:0] goal,
                                          input logic [1:0] dir);
    logic [1:0]   mode_req;
    posn_report_t tail;
    fresh.delete();
    mode_req = (dir == MOT_SPARE) ? MOT_STOP : dir;
    case (cmd)
      CMD_TICK: begin
        if (run_mode != MOT_STOP) begin
          if (sense != sense_prev) begin
            sense_prev = sense;
            if (run_mode == MOT_DEC) begin
              count_now = saturate(int'(count_now) - 1);
            end else if (run_mode == MOT_INC) begin
              count_now = saturate(int'(count_now) + 1);
            end
            fresh.push_back(now_report(EV_POS));
          end
          if (goal_on && ((run_mode == MOT_INC && count_now >= goal_now) ||
                          (run_mode == MOT_DEC && count_now <= goal_now))) begin
            run_mode = MOT_STOP;
            fresh.push_back(now_report(EV_MOTION));
          end
        end
      end
      CMD_SET_TARGET: begin
        goal_now = goal;
        goal_on = 1'b1;
        fresh.push_back(now_report(EV_TARGET));
        if (goal_now > count_now) begin
          run_mode = MOT_INC;
          fresh.push_back(now_report(EV_MOTION));
        end else if (goal_now < count_now) begin
          run_mode = MOT_DEC;
          fresh.push_back(now_report(EV_MOTION));
        end
      end
      CMD_SET_MOTION: begin
        goal_on = 1'b0;
        if (run_mode != mode_req) begin
          run_mode = mode_req;
          fresh.push_back(now_report(EV_MOTION));
        end
      end
      CMD_MARK_BOTTOM: begin
        limit_now = count_now;
        fresh.push_back(now_report(EV_BOTTOM));
      end
      CMD_MARK_TOP: begin
        limit_now = saturate(int'(limit_now) - int'(count_now));
        if (goal_on) begin
          goal_now = saturate(int'(goal_now) - int'(count_now));
        end
        count_now = '0;
        fresh.push_back(now_report(EV_TOP));
      end
      default: begin
      end
    endcase
    if (fresh.size() == 0) begin
      fresh.push_back(now_report(EV_NONE));
    end
    tail = fresh.pop_back();
    tail.last = 1'b1;
    fresh.push_back(tail);
  endfunction

  // transfers on both channels, prediction and comparison
  always @(posedge clk) begin : watch
    posn_report_t got;
    posn_report_t want;
    if (!rst_n) begin
      run_mode = MOT_STOP;
      count_now = '0;
      goal_now = '0;
      goal_on = 1'b0;
      limit_now = '0;
      sense_prev = 1'b0;
      awaited.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_command(in_command, in_sense, in_goal, in_direction);
        if (row_known) begin
          awaited.push_back(row_want);
        end else begin
          foreach (fresh[i]) begin
            awaited.push_back(fresh[i]);
          end
        end
        items_taken++;
      end
      if (out_valid && out_ready) begin
        got = make_report(out_event_res, out_last, out_motion, out_position, out_target_out,
                          out_target_valid, out_limit_out);
        got.up = out_motor_up;
        got.down = out_motor_down;
        if (awaited.size() == 0) begin
          note_mismatch("unexpected result, event", got.ev, -1);
        end else begin
          want = awaited.pop_front();
          if (got.ev !== want.ev) note_mismatch("event_res", got.ev, want.ev);
          if (got.last !== want.last) note_mismatch("last", got.last, want.last);
          if (got.up !== want.up) note_mismatch("motor_up", got.up, want.up);
          if (got.down !== want.down) note_mismatch("motor_down", got.down, want.down);
          if (got.motion !== want.motion) note_mismatch("motion", got.motion, want.motion);
          if (got.position !== want.position) begin
            note_mismatch("position", got.position, want.position);
          end
          if (got.target !== want.target) note_mismatch("target_out", got.target, want.target);
          if (got.tvalid !== want.tvalid) begin
            note_mismatch("target_valid", got.tvalid, want.tvalid);
          end
          if (got.limit !== want.limit) note_mismatch("limit_out", got.limit, want.limit);
        end
        results_seen++;
      end
    end
  end

  // receiver: random stalls, one long hold-off, a calm stretch
  initial begin : receiver
    int   hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // one command transfer, entered and left at a falling edge
  task automatic offer(input logic [2:0] cmd, input logic sense,
                       input logic signed [15:0] goal, input logic [1:0] dir,
                       input logic known, input posn_report_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_known = known;
    row_want = want;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sense <= sense;
    in_goal <= goal;
    in_direction <= dir;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  function automatic plan_row_t plan_step(input logic [2:0] cmd, input logic sense,
                                          input logic signed [15:0] goal,
                                          input logic [1:0] dir, input logic known,
                                          input posn_report_t want);
    plan_row_t r;
    r.cmd = cmd;
    r.sense = sense;
    r.goal = goal;
    r.dir = dir;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  initial begin : stimulus
    plan_row_t          plan[$];
    int                 k;
    int                 pick;
    int                 guard;
    logic [2:0]         cmd;
    logic               level;
    logic signed [15:0] aim;
    logic [1:0]         dir;

    in_valid <= 1'b0;
    in_command <= CMD_TICK;
    in_sense <= 1'b0;
    in_goal <= '0;
    in_direction <= MOT_STOP;
    rst_n <= 1'b0;

    // cmd, sense, goal, direction, typed-in result
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b1,
                             make_report(EV_NONE, 1'b1, MOT_STOP, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_SPARE_C, 1'b1, -16'sd1, MOT_SPARE, 1'b1,
                             make_report(EV_NONE, 1'b1, MOT_STOP, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_MARK_BOTTOM, 1'b0, 16'sd0, MOT_STOP, 1'b1,
                             make_report(EV_BOTTOM, 1'b1, MOT_STOP, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_MARK_TOP, 1'b0, 16'sd0, MOT_STOP, 1'b1,
                             make_report(EV_TOP, 1'b1, MOT_STOP, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_SET_MOTION, 1'b0, 16'sd0, MOT_SPARE, 1'b1,
                             make_report(EV_NONE, 1'b1, MOT_STOP, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_SET_MOTION, 1'b0, 16'sd0, MOT_INC, 1'b1,
                             make_report(EV_MOTION, 1'b1, MOT_INC, '0, '0, 1'b0, '0)));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_TARGET, 1'b0, 16'sd4, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_TARGET, 1'b0, POS_MIN, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_MARK_BOTTOM, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_MARK_TOP, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_TARGET, 1'b0, POS_MAX, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_TARGET, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_TICK, 1'b1, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_MOTION, 1'b0, 16'sd0, MOT_DEC, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_MOTION, 1'b0, 16'sd0, MOT_DEC, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SPARE_A, 1'b0, 16'sd0, MOT_INC, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SPARE_B, 1'b1, POS_MAX, MOT_DEC, 1'b0, NO_REPORT));
    plan.push_back(plan_step(CMD_SET_MOTION, 1'b0, 16'sd0, MOT_STOP, 1'b0, NO_REPORT));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      offer(plan[i].cmd, plan[i].sense, plan[i].goal, plan[i].dir, plan[i].known,
            plan[i].want);
    end

    // mostly ticks with sense changes, targets near the count so they get reached
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(99);
      level = ($urandom_range(99) < 70) ? ~sense_prev : sense_prev;
      if ($urandom_range(3) == 0) begin
        aim = 16'($urandom);
      end else begin
        aim = saturate(int'(count_now) + int'($urandom_range(40)) - 20);
      end
      dir = 2'($urandom);
      if (pick < 55) begin
        cmd = CMD_TICK;
      end else if (pick < 67) begin
        cmd = CMD_SET_TARGET;
      end else if (pick < 79) begin
        cmd = CMD_SET_MOTION;
      end else if (pick < 86) begin
        cmd = CMD_MARK_BOTTOM;
      end else if (pick < 93) begin
        cmd = CMD_MARK_TOP;
      end else begin
        cmd = CMD_SPARE_A + 3'($urandom_range(2));
      end
      offer(cmd, level, aim, dir, 1'b0, NO_REPORT);
    end

    // far targets, then re-zero with saturating shifts
    offer(CMD_SET_TARGET, sense_prev, POS_MIN, MOT_STOP, 1'b0, NO_REPORT);
    offer(CMD_MARK_TOP, sense_prev, 16'sd0, MOT_STOP, 1'b0, NO_REPORT);
    offer(CMD_SET_TARGET, sense_prev, POS_MAX, MOT_STOP, 1'b0, NO_REPORT);
    offer(CMD_MARK_TOP, sense_prev, 16'sd0, MOT_STOP, 1'b0, NO_REPORT);
    offer(CMD_SET_MOTION, sense_prev, 16'sd0, MOT_STOP, 1'b0, NO_REPORT);
    in_valid <= 1'b0;

    for (guard = 0; guard < 2000 && awaited.size() != 0; guard++) begin
      @(negedge clk);
    end
    if (awaited.size() != 0) begin
      note_mismatch("results never delivered, count", 0, awaited.size());
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(1_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== edge_counting_blind_positioner_core.f =====
+incdir+hw/rtl
hw/rtl/ecbp_pkg.sv
hw/rtl/ecbp_step.sv
hw/rtl/ecbp_res_fifo.sv
hw/rtl/edge_counting_blind_positioner_core.sv
tb/testbench.sv
